// ===== rtl/swrs_pkg.sv =====
`default_nettype none
package swrs_pkg;

  // Build-time defaults for the top level parameters.
  localparam int WINDOW_MAX_DEF = 64;
  localparam int PRICE_BITS_DEF = 24;

  // Window length setting: the width of its config port, its value after reset and its floor.
  localparam int CFG_W          = 7;
  localparam int WINDOW_DEFAULT = 20;
  localparam int WINDOW_MIN     = 2;

  // Slope format, signed Q16.16, and the quotient the divider produces.
  localparam int BETA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int QUOT_W    = BETA_W + 1;
  localparam int PRE_SHIFT = QUOT_W - FRAC_BITS - 1;

  localparam logic [BETA_W-1:0] BETA_MAX = {1'b0, {(BETA_W-1){1'b1}}};
  localparam logic [BETA_W-1:0] BETA_MIN = {1'b1, {(BETA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_WARMUP    = 2'd0,
    ST_VALID     = 2'd1,
    ST_FLAT      = 2'd2,
    ST_SATURATED = 2'd3
  } status_t;

  // Per-cycle control of the shared multiply/add unit.
  typedef struct packed {
    logic mul_en;    // load a new product
    logic use_prod;  // second adder operand is the last product
    logic prod_hi;   // product is shifted up by one operand width
    logic subtract;  // adder computes a - b
  } alu_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/sliding_window_regression_slope.sv =====
`default_nettype none
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall   in_low_price, in_high_price, in_start_of_series
// out       output     out_valid / out_stall out_beta (signed Q16.16), out_status
// cfg       input      cfg_write_en          cfg_window_length
//
// A bar whose window is full passes the sum updates, the products, the 33-step restoring
// divider and the rounding before its result beat is loaded into the output register.
// A bar still warming up skips the products; a flat window or an early overflow skips the divider.
// One bar is worked on at a time; in_stall is high from acceptance until the result is
// loaded, while a result held by out_stall does not block the next input beat.
// rst_n is synchronous and active low; it clears the sums and counters and resets the window length.
module sliding_window_regression_slope #(
  parameter int WINDOW_MAX = swrs_pkg::WINDOW_MAX_DEF,
  parameter int PRICE_BITS = swrs_pkg::PRICE_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire  [PRICE_BITS-1:0]               in_low_price,
  input  wire  [PRICE_BITS-1:0]               in_high_price,
  input  wire                                 in_start_of_series,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic signed [swrs_pkg::BETA_W-1:0]  out_beta,
  output logic [1:0]                          out_status,
  input  wire                                 cfg_write_en,
  input  wire  [swrs_pkg::CFG_W-1:0]          cfg_window_length
);

  // Widths. The window count needs to hold WINDOW_MAX itself, the slot index does not.
  localparam int SLOT_W  = $clog2(WINDOW_MAX);
  localparam int WIN_W   = $clog2(WINDOW_MAX + 1);
  localparam int AW      = WIN_W + 1;
  localparam int SUM1_W  = PRICE_BITS + SLOT_W;
  localparam int SUM2_W  = 2 * PRICE_BITS + SLOT_W;
  localparam int OPW     = SUM1_W;
  localparam int PROD_W  = 2 * OPW;
  localparam int ADD_W   = PROD_W + 2;
  localparam int QUOT_W  = swrs_pkg::QUOT_W;
  localparam int BETA_W  = swrs_pkg::BETA_W;
  localparam int CNT_W   = $clog2(QUOT_W);
  localparam int CW      = (WIN_W > swrs_pkg::CFG_W) ? WIN_W : swrs_pkg::CFG_W;
  localparam int RESET_N = (swrs_pkg::WINDOW_DEFAULT > WINDOW_MAX) ?
                           WINDOW_MAX : swrs_pkg::WINDOW_DEFAULT;

  // Sequencer: one state per step of the shared unit's schedule, the divider loop in one state.
  typedef enum logic [17:0] {
    S_IDLE = 18'h00001,
    S_RD   = 18'h00002,
    S_M1   = 18'h00004,
    S_M2   = 18'h00008,
    S_M3   = 18'h00010,
    S_M4   = 18'h00020,
    S_P0   = 18'h00040,
    S_P1   = 18'h00080,
    S_P2   = 18'h00100,
    S_P3   = 18'h00200,
    S_P4   = 18'h00400,
    S_P5   = 18'h00800,
    S_P6   = 18'h01000,
    S_ABS  = 18'h02000,
    S_CHK  = 18'h04000,
    S_DIV  = 18'h08000,
    S_RND  = 18'h10000,
    S_OUT  = 18'h20000
  } state_t;

  state_t state_r, state_nxt;

  logic [WIN_W-1:0]  window_length_r, window_length_nxt;
  logic [WIN_W-1:0]  bars_seen_r, bars_seen_nxt;
  logic [SLOT_W-1:0] write_slot_r, write_slot_nxt;
  logic              evict_r, evict_nxt;
  logic [PRICE_BITS-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [SUM1_W-1:0] sum_l_r, sum_l_nxt, sum_h_r, sum_h_nxt;
  logic [SUM2_W-1:0] sum_lh_r, sum_lh_nxt, sum_ll_r, sum_ll_nxt;
  logic [ADD_W-1:0]  den_r, den_nxt, num_r, num_nxt;
  logic [PROD_W-1:0] mag_r, mag_nxt, rem_r, rem_nxt;
  logic              neg_r, neg_nxt;
  logic [QUOT_W-1:0] div_bits_r, div_bits_nxt, quot_r, quot_nxt;
  logic [CNT_W-1:0]  div_cnt_r, div_cnt_nxt;
  logic [BETA_W-1:0] res_beta_r, res_beta_nxt;
  swrs_pkg::status_t res_status_r, res_status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic signed [BETA_W-1:0] out_beta_r, out_beta_nxt;
  swrs_pkg::status_t out_status_r, out_status_nxt;

  // History of bars, high price in the upper half of each word.
  logic [2*PRICE_BITS-1:0] hist_mem [WINDOW_MAX];
  logic [2*PRICE_BITS-1:0] hist_rd_r;
  logic                    hist_we, hist_re;
  logic [SLOT_W-1:0]       rd_addr;

  // Shared unit interface.
  swrs_pkg::alu_ctrl_t alu_ctrl;
  logic [OPW-1:0]      mul_a, mul_b;
  logic [ADD_W-1:0]    add_a, add_b, add_y;

  // Helpers for the accept step, the eviction and the last steps.
  logic [SLOT_W-1:0]     acc_slot;
  logic [WIN_W-1:0]      acc_seen;
  logic [AW-1:0]         old_diff;
  logic [PRICE_BITS-1:0] old_low, old_high;
  logic [PROD_W:0]       rem_shift;
  logic                  qbit;
  logic [QUOT_W:0]       rnd_sum;
  logic [QUOT_W-1:0]     mag_q;
  logic                  rnd_sat;
  logic [CW-1:0]         cfg_ext;
  logic [WIN_W-1:0]      cfg_clamped;
  logic                  out_free;
  logic                  den_flat;

  swrs_alu #(
    .OPW (OPW)
  ) u_alu (
    .clk   (clk),
    .ctrl  (alu_ctrl),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .add_a (add_a),
    .add_b (add_b),
    .add_y (add_y)
  );

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_beta   = out_beta_r;
  assign out_status = out_status_r;

  // The evicted bar only counts once the window is full; otherwise it reads as zero.
  assign old_low  = evict_r ? hist_rd_r[PRICE_BITS-1:0] : '0;
  assign old_high = evict_r ? hist_rd_r[2*PRICE_BITS-1:PRICE_BITS] : '0;

  assign out_free  = !out_valid_r || !out_stall;
  assign den_flat  = den_r[ADD_W-1] || (den_r == '0);
  assign rem_shift = {rem_r, div_bits_r[QUOT_W-1]};

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[acc_slot] <= {in_high_price, in_low_price};
    end
    if (hist_re) begin
      hist_rd_r <= hist_mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt         = state_r;
    window_length_nxt = window_length_r;
    bars_seen_nxt     = bars_seen_r;
    write_slot_nxt    = write_slot_r;
    evict_nxt         = evict_r;
    x_nxt             = x_r;
    y_nxt             = y_r;
    sum_l_nxt         = sum_l_r;
    sum_h_nxt         = sum_h_r;
    sum_lh_nxt        = sum_lh_r;
    sum_ll_nxt        = sum_ll_r;
    den_nxt           = den_r;
    num_nxt           = num_r;
    mag_nxt           = mag_r;
    rem_nxt           = rem_r;
    neg_nxt           = neg_r;
    div_bits_nxt      = div_bits_r;
    quot_nxt          = quot_r;
    div_cnt_nxt       = div_cnt_r;
    res_beta_nxt      = res_beta_r;
    res_status_nxt    = res_status_r;
    out_beta_nxt      = out_beta_r;
    out_status_nxt    = out_status_r;
    out_valid_nxt     = out_valid_r && out_stall;

    alu_ctrl = '0;
    mul_a    = '0;
    mul_b    = '0;
    add_a    = '0;
    add_b    = '0;
    hist_we  = 1'b0;
    hist_re  = 1'b0;

    // A start flag restarts the series before this bar is taken.
    acc_slot = in_start_of_series ? '0 : write_slot_r;
    acc_seen = in_start_of_series ? '0 : bars_seen_r;

    // Slot of the bar that leaves the window, modulo the history depth.
    old_diff = AW'(acc_slot) - AW'(window_length_r);
    if (AW'(acc_slot) >= AW'(window_length_r)) begin
      rd_addr = old_diff[SLOT_W-1:0];
    end else begin
      rd_addr = SLOT_W'(old_diff + AW'(WINDOW_MAX));
    end

    qbit    = 1'b0;
    rnd_sum = {1'b0, quot_r} + 1'b1;
    mag_q   = rnd_sum[QUOT_W:1];
    if (neg_r) begin
      rnd_sat = mag_q[QUOT_W-1] || (mag_q[BETA_W-1] && (mag_q[BETA_W-2:0] != '0));
    end else begin
      rnd_sat = (mag_q[QUOT_W-1:BETA_W-1] != '0);
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          hist_we = 1'b1;
          hist_re = 1'b1;
          x_nxt   = in_low_price;
          y_nxt   = in_high_price;
          if (in_start_of_series) begin
            sum_l_nxt  = '0;
            sum_h_nxt  = '0;
            sum_lh_nxt = '0;
            sum_ll_nxt = '0;
          end
          evict_nxt = (acc_seen >= window_length_r);
          if (acc_slot == SLOT_W'(WINDOW_MAX - 1)) begin
            write_slot_nxt = '0;
          end else begin
            write_slot_nxt = acc_slot + 1'b1;
          end
          if (acc_seen < window_length_r) begin
            bars_seen_nxt = acc_seen + 1'b1;
          end else begin
            bars_seen_nxt = acc_seen;
          end
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        alu_ctrl.mul_en = 1'b1;
        mul_a = OPW'(x_r);
        mul_b = OPW'(y_r);
        sum_l_nxt = sum_l_r + SUM1_W'(x_r) - SUM1_W'(old_low);
        sum_h_nxt = sum_h_r + SUM1_W'(y_r) - SUM1_W'(old_high);
        state_nxt = S_M1;
      end
      S_M1: begin
        alu_ctrl.mul_en   = 1'b1;
        alu_ctrl.use_prod = 1'b1;
        mul_a = OPW'(x_r);
        mul_b = OPW'(x_r);
        add_a = ADD_W'(sum_lh_r);
        sum_lh_nxt = add_y[SUM2_W-1:0];
        state_nxt  = S_M2;
      end
      S_M2: begin
        alu_ctrl.mul_en   = 1'b1;
        alu_ctrl.use_prod = 1'b1;
        mul_a = OPW'(old_low);
        mul_b = OPW'(old_high);
        add_a = ADD_W'(sum_ll_r);
        sum_ll_nxt = add_y[SUM2_W-1:0];
        state_nxt  = S_M3;
      end
      S_M3: begin
        alu_ctrl.mul_en   = 1'b1;
        alu_ctrl.use_prod = 1'b1;
        alu_ctrl.subtract = 1'b1;
        mul_a = OPW'(old_low);
        mul_b = OPW'(old_low);
        add_a = ADD_W'(sum_lh_r);
        sum_lh_nxt = add_y[SUM2_W-1:0];
        state_nxt  = S_M4;
      end
      S_M4: begin
        alu_ctrl.use_prod = 1'b1;
        alu_ctrl.subtract = 1'b1;
        add_a = ADD_W'(sum_ll_r);
        sum_ll_nxt = add_y[SUM2_W-1:0];
        if (bars_seen_r < window_length_r) begin
          res_beta_nxt   = '0;
          res_status_nxt = swrs_pkg::ST_WARMUP;
          state_nxt      = S_OUT;
        end else begin
          state_nxt = S_P0;
        end
      end
      S_P0: begin
        alu_ctrl.mul_en = 1'b1;
        mul_a = OPW'(window_length_r);
        mul_b = sum_ll_r[OPW-1:0];
        state_nxt = S_P1;
      end
      S_P1: begin
        alu_ctrl.mul_en   = 1'b1;
        alu_ctrl.use_prod = 1'b1;
        mul_a = OPW'(window_length_r);
        mul_b = OPW'(sum_ll_r[SUM2_W-1:OPW]);
        den_nxt   = add_y;
        state_nxt = S_P2;
      end
      S_P2: begin
        alu_ctrl.mul_en   = 1'b1;
        alu_ctrl.use_prod = 1'b1;
        alu_ctrl.prod_hi  = 1'b1;
        mul_a = sum_l_r;
        mul_b = sum_l_r;
        add_a = den_r;
        den_nxt   = add_y;
        state_nxt = S_P3;
      end
      S_P3: begin
        alu_ctrl.mul_en   = 1'b1;
        alu_ctrl.use_prod = 1'b1;
        alu_ctrl.subtract = 1'b1;
        mul_a = OPW'(window_length_r);
        mul_b = sum_lh_r[OPW-1:0];
        add_a = den_r;
        den_nxt   = add_y;
        state_nxt = S_P4;
      end
      S_P4: begin
        alu_ctrl.mul_en   = 1'b1;
        alu_ctrl.use_prod = 1'b1;
        mul_a = OPW'(window_length_r);
        mul_b = OPW'(sum_lh_r[SUM2_W-1:OPW]);
        num_nxt   = add_y;
        state_nxt = S_P5;
      end
      S_P5: begin
        alu_ctrl.mul_en   = 1'b1;
        alu_ctrl.use_prod = 1'b1;
        alu_ctrl.prod_hi  = 1'b1;
        mul_a = sum_l_r;
        mul_b = sum_h_r;
        add_a = num_r;
        num_nxt   = add_y;
        state_nxt = S_P6;
      end
      S_P6: begin
        alu_ctrl.use_prod = 1'b1;
        alu_ctrl.subtract = 1'b1;
        add_a = num_r;
        num_nxt   = add_y;
        state_nxt = S_ABS;
      end
      S_ABS: begin
        // All lows equal leaves no spread to divide by.
        if (den_flat) begin
          res_beta_nxt   = '0;
          res_status_nxt = swrs_pkg::ST_FLAT;
          state_nxt      = S_OUT;
        end else begin
          alu_ctrl.subtract = 1'b1;
          add_b   = num_r;
          neg_nxt = num_r[ADD_W-1];
          if (num_r[ADD_W-1]) begin
            mag_nxt = add_y[PROD_W-1:0];
          end else begin
            mag_nxt = num_r[PROD_W-1:0];
          end
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        // A quotient too wide for the divider is an overflow in any case.
        alu_ctrl.subtract = 1'b1;
        add_a = ADD_W'(mag_r >> swrs_pkg::PRE_SHIFT);
        add_b = den_r;
        if (!add_y[ADD_W-1]) begin
          res_beta_nxt   = neg_r ? swrs_pkg::BETA_MIN : swrs_pkg::BETA_MAX;
          res_status_nxt = swrs_pkg::ST_SATURATED;
          state_nxt      = S_OUT;
        end else begin
          rem_nxt      = mag_r >> swrs_pkg::PRE_SHIFT;
          div_bits_nxt = QUOT_W'(mag_r[swrs_pkg::PRE_SHIFT-1:0]) << (swrs_pkg::FRAC_BITS + 1);
          quot_nxt     = '0;
          div_cnt_nxt  = CNT_W'(QUOT_W - 1);
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        alu_ctrl.subtract = 1'b1;
        add_a = ADD_W'(rem_shift);
        add_b = den_r;
        qbit  = !add_y[ADD_W-1];
        if (qbit) begin
          rem_nxt = add_y[PROD_W-1:0];
        end else begin
          rem_nxt = rem_shift[PROD_W-1:0];
        end
        div_bits_nxt = div_bits_r << 1;
        quot_nxt     = {quot_r[QUOT_W-2:0], qbit};
        div_cnt_nxt  = div_cnt_r - 1'b1;
        if (div_cnt_r == '0) begin
          state_nxt = S_RND;
        end
      end
      S_RND: begin
        // The quotient carries one extra fraction bit; round half away from zero.
        if (rnd_sat) begin
          res_beta_nxt   = neg_r ? swrs_pkg::BETA_MIN : swrs_pkg::BETA_MAX;
          res_status_nxt = swrs_pkg::ST_SATURATED;
        end else begin
          res_beta_nxt   = neg_r ? (~mag_q[BETA_W-1:0] + 1'b1) : mag_q[BETA_W-1:0];
          res_status_nxt = swrs_pkg::ST_VALID;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_beta_nxt   = res_beta_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A window write, whatever its value, restarts the series.
    cfg_ext = CW'(cfg_window_length);
    if (cfg_ext < CW'(swrs_pkg::WINDOW_MIN)) begin
      cfg_clamped = WIN_W'(swrs_pkg::WINDOW_MIN);
    end else if (cfg_ext > CW'(WINDOW_MAX)) begin
      cfg_clamped = WIN_W'(WINDOW_MAX);
    end else begin
      cfg_clamped = WIN_W'(cfg_ext);
    end
    if (cfg_write_en) begin
      window_length_nxt = cfg_clamped;
      sum_l_nxt         = '0;
      sum_h_nxt         = '0;
      sum_lh_nxt        = '0;
      sum_ll_nxt        = '0;
      bars_seen_nxt     = '0;
      write_slot_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      window_length_r <= WIN_W'(RESET_N);
      bars_seen_r     <= '0;
      write_slot_r    <= '0;
      sum_l_r         <= '0;
      sum_h_r         <= '0;
      sum_lh_r        <= '0;
      sum_ll_r        <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      window_length_r <= window_length_nxt;
      bars_seen_r     <= bars_seen_nxt;
      write_slot_r    <= write_slot_nxt;
      sum_l_r         <= sum_l_nxt;
      sum_h_r         <= sum_h_nxt;
      sum_lh_r        <= sum_lh_nxt;
      sum_ll_r        <= sum_ll_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    evict_r      <= evict_nxt;
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    den_r        <= den_nxt;
    num_r        <= num_nxt;
    mag_r        <= mag_nxt;
    rem_r        <= rem_nxt;
    neg_r        <= neg_nxt;
    div_bits_r   <= div_bits_nxt;
    quot_r       <= quot_nxt;
    div_cnt_r    <= div_cnt_nxt;
    res_beta_r   <= res_beta_nxt;
    res_status_r <= res_status_nxt;
    out_beta_r   <= out_beta_nxt;
    out_status_r <= out_status_nxt;
  end

  // An accepted bar keeps the input side closed on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
      (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted again right after a bar was taken");

  // Warming up and flat windows report a zero slope.
  a_zero_slope: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid && (out_status_r == swrs_pkg::ST_WARMUP ||
                     out_status_r == swrs_pkg::ST_FLAT)) |-> (out_beta == '0))
    else $error("nonzero slope with warming up or flat status");

  // A saturated slope sits at one of the format limits.
  a_sat_limits: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid && out_status_r == swrs_pkg::ST_SATURATED) |->
      (out_beta_r == swrs_pkg::BETA_MAX || out_beta_r == swrs_pkg::BETA_MIN))
    else $error("saturated status without a limit value");

  // A finished result waits while the output register is still held.
  a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == S_OUT && out_valid_r && out_stall) |=> (state_r == S_OUT))
    else $error("result left the sequencer while the output beat was stalled");

  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
      bars_seen_r <= window_length_r)
    else $error("bar count ran past the window length");

endmodule
`default_nettype wire

// ===== rtl/swrs_alu.sv =====
`default_nettype none
module swrs_alu #(
  parameter int OPW = swrs_pkg::PRICE_BITS_DEF + 6
) (
  input  wire                     clk,
  input  var swrs_pkg::alu_ctrl_t ctrl,
  input  wire  [OPW-1:0]          mul_a,
  input  wire  [OPW-1:0]          mul_b,
  input  wire  [2*OPW+1:0]        add_a,
  input  wire  [2*OPW+1:0]        add_b,
  output logic [2*OPW+1:0]        add_y
);

  localparam int PROD_W = 2 * OPW;
  localparam int ADD_W  = PROD_W + 2;

  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_nxt;
  logic [ADD_W-1:0]  b_sel;
  logic [ADD_W-1:0]  b_eff;

  // The product is registered; the adder takes it from that register in the next cycle.
  assign prod_nxt = {{OPW{1'b0}}, mul_a} * {{OPW{1'b0}}, mul_b};

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= prod_nxt;
    end
  end

  always_comb begin
    if (ctrl.use_prod) begin
      if (ctrl.prod_hi) begin
        b_sel = ADD_W'(prod_r) << OPW;
      end else begin
        b_sel = ADD_W'(prod_r);
      end
    end else begin
      b_sel = add_b;
    end
    b_eff = ctrl.subtract ? ~b_sel : b_sel;
    add_y = add_a + b_eff + ADD_W'(ctrl.subtract);
  end

endmodule
`default_nettype wire
